### design/xkb64_pkg.sv
`timescale 1ns / 1ps

package xkb64_pkg;

    // Key storage
    localparam int KEY_BYTES = 16;
    localparam int KEY_POS_W = $clog2(KEY_BYTES);
    localparam int KEY_LEN_W = 5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // Group queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // One classified group handed from front to back
    typedef struct packed {
        logic [23:0] word;   // first byte in bits 23..16
        logic [1:0]  total;  // bytes in the group, 1..3
        logic        last;   // group closes the message
    } t_group;

    // Map a 6-bit value to the standard base64 alphabet
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            if (v < 6'd26) begin
                c = 8'h41 + {2'b00, v};
            end else if (v < 6'd52) begin
                c = 8'h61 + {2'b00, v - 6'd26};
            end else if (v < 6'd62) begin
                c = 8'h30 + {2'b00, v - 6'd52};
            end else if (v == 6'd62) begin
                c = 8'h2B;
            end else begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

### design/xkb64_front.sv
`timescale 1ns / 1ps

module xkb64_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_plain_byte,
    input  logic                       i_end_of_message,
    input  logic                       i_cfg_valid,
    input  logic [xkb64_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                i_cfg_data,
    input  logic                       i_queue_full,
    output logic                       o_push,
    output xkb64_pkg::t_group          o_push_group
);
    import xkb64_pkg::*;

    logic [63:0]          r_key_low;
    logic [63:0]          r_key_high;
    logic [KEY_LEN_W-1:0] r_key_len;
    logic [KEY_POS_W-1:0] r_pos, n_pos;
    logic [15:0]          r_group, n_group;
    logic [1:0]           r_fill, n_fill;

    logic [127:0]         w_key;
    logic [7:0]           w_byte;
    logic [KEY_LEN_W-1:0] w_eff_len;
    logic [KEY_LEN_W-1:0] w_pos_inc;
    logic                 w_accept;
    logic                 w_close;
    logic [23:0]          w_word;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign w_key    = {r_key_high, r_key_low};
    assign w_byte   = i_plain_byte ^ w_key[{r_pos, 3'b000} +: 8];
    assign w_close  = (r_fill == 2'd2) || i_end_of_message;

    always_comb begin
        w_eff_len = r_key_len;
        if (r_key_len == '0) begin
            w_eff_len = KEY_LEN_W'(1);
        end else if (r_key_len > KEY_LEN_W'(KEY_BYTES)) begin
            w_eff_len = KEY_LEN_W'(KEY_BYTES);
        end
        w_pos_inc = {1'b0, r_pos} + KEY_LEN_W'(1);

        case (r_fill)
            2'd0:    w_word = {w_byte, 16'h0000};
            2'd1:    w_word = {r_group[15:8], w_byte, 8'h00};
            default: w_word = {r_group, w_byte};
        endcase

        n_pos   = r_pos;
        n_group = r_group;
        n_fill  = r_fill;
        if (w_accept) begin
            n_pos = (w_pos_inc >= w_eff_len) ? '0 : w_pos_inc[KEY_POS_W-1:0];
            if (w_close) begin
                n_group = '0;
                n_fill  = 2'd0;
                if (i_end_of_message) begin
                    n_pos = '0;
                end
            end else begin
                n_group = (r_fill == 2'd0) ? {w_byte, 8'h00} : {r_group[15:8], w_byte};
                n_fill  = r_fill + 2'd1;
            end
        end
    end

    assign o_push             = w_accept && w_close;
    assign o_push_group.word  = w_word;
    assign o_push_group.total = r_fill + 2'd1;
    assign o_push_group.last  = i_end_of_message;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= KEY_LEN_W'(KEY_BYTES);
            r_pos      <= '0;
            r_group    <= '0;
            r_fill     <= 2'd0;
        end else begin
            r_pos   <= n_pos;
            r_group <= n_group;
            r_fill  <= n_fill;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                    CFG_KEY_LEN:  r_key_len  <= i_cfg_data[KEY_LEN_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

endmodule

### design/xkb64_queue.sv
`timescale 1ns / 1ps

module xkb64_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  xkb64_pkg::t_group i_push_group,
    output logic              o_full,
    input  logic              i_pop,
    output xkb64_pkg::t_group o_pop_group,
    output logic              o_empty
);
    import xkb64_pkg::*;

    t_group                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr;
    logic [QUEUE_PTR_W-1:0] r_rptr;
    logic [QUEUE_PTR_W:0]   r_count;

    assign o_full      = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty     = (r_count == '0);
    assign o_pop_group = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

### design/xkb64_back.sv
`timescale 1ns / 1ps

module xkb64_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  xkb64_pkg::t_group i_group,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_text_char,
    output logic              o_final_char
);
    import xkb64_pkg::*;

    t_group     r_cur;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_text;
    logic       r_final;

    logic       w_emit;
    logic [5:0] w_sextet;
    logic [7:0] w_char;

    assign w_emit = r_busy && (!r_out_valid || i_ready);
    // Take the next group when idle or while the last character goes out
    assign o_pop  = !i_empty && (!r_busy || (w_emit && r_idx == 2'd3));

    always_comb begin
        case (r_idx)
            2'd0:    w_sextet = r_cur.word[23:18];
            2'd1:    w_sextet = r_cur.word[17:12];
            2'd2:    w_sextet = r_cur.word[11:6];
            default: w_sextet = r_cur.word[5:0];
        endcase
        w_char = (r_idx <= r_cur.total) ? b64_char(w_sextet) : CHAR_PAD;
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_text  <= w_char;
            r_final <= r_cur.last && (r_idx == 2'd3);
        end
        if (o_pop) begin
            r_cur <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + 2'd1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_emit && r_idx == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_text_char  = r_text;
    assign o_final_char = r_final;

endmodule

### design/xor_key_base64_encoder_core.sv
`timescale 1ns / 1ps

// Channel   | Signals                                        | Direction
// ----------+------------------------------------------------+----------
// input     | i_valid, o_ready, i_plain_byte, i_end_of_message | in
// output    | o_valid, i_ready, o_text_char, o_final_char    | out
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// Each request on the input channel passes through the front; every third
// byte (or the last byte of a message) closes a group that yields four
// characters, one per cycle from the back while a group is waiting and the
// output is not stalled. The two-entry group queue sets how far the front runs ahead.
// Reset (synchronous, active low) clears position, partial group, queue and
// output; the key resets to zero and the key length to sixteen.
// A stall on the output holds the current character; the front keeps taking
// bytes until the queue fills. Config requests are always accepted.

module xor_key_base64_encoder_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // plaintext requests
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_plain_byte,
    input  logic                       i_end_of_message,
    // encoded characters
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_text_char,
    output logic                       o_final_char,
    // configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [xkb64_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                i_cfg_data
);
    import xkb64_pkg::*;

    logic   w_push;
    t_group w_push_group;
    logic   w_full;
    logic   w_pop;
    t_group w_pop_group;
    logic   w_empty;

    // Register writes never stall
    assign o_cfg_ready = 1'b1;

    // Front: XOR with the key byte, gather bytes into groups of up to three
    xkb64_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_plain_byte    (i_plain_byte),
        .i_end_of_message(i_end_of_message),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_queue_full    (w_full),
        .o_push          (w_push),
        .o_push_group    (w_push_group)
    );

    // Hold closed groups so front and back stall independently
    xkb64_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_group(w_push_group),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_group (w_pop_group),
        .o_empty     (w_empty)
    );

    // Back: expand each group into four base64 characters
    xkb64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_group     (w_pop_group),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_final_char(o_final_char)
    );

endmodule

### design/xkb64_checker.sv
`timescale 1ns / 1ps

module xkb64_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_text_char,
    input logic       o_final_char
);
    import xkb64_pkg::*;

    // Output drops after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Stalled character holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_text_char) && $stable(o_final_char))
        else $error("stalled character changed");

    // Every character is from the alphabet or padding
    a_legal_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_text_char >= 8'h41 && o_text_char <= 8'h5A) ||
                    (o_text_char >= 8'h61 && o_text_char <= 8'h7A) ||
                    (o_text_char >= 8'h30 && o_text_char <= 8'h39) ||
                    o_text_char == 8'h2B || o_text_char == 8'h2F ||
                    o_text_char == CHAR_PAD)
        else $error("illegal character");

    // A non-final pad is followed directly by the final pad
    a_pad_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_text_char == CHAR_PAD && !o_final_char |=>
            !o_valid || (o_text_char == CHAR_PAD && o_final_char))
        else $error("padding not closed by final pad");

endmodule

bind xor_key_base64_encoder_core xkb64_checker u_xkb64_checker (.*);
